// ----- rtl/rle4_pkg.sv -----
// Shared types and constants for the 4-bit run-length decoder.
package rle4_pkg;

  localparam int BYTE_COUNT_WIDTH = 24;
  localparam logic [BYTE_COUNT_WIDTH-1:0] PLANE_BYTES_RESET = BYTE_COUNT_WIDTH'(307200);

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Code byte low nibble meanings when the high nibble is zero
  localparam logic [3:0] CODE_END  = 4'h0;
  localparam logic [3:0] CODE_LONG = 4'h1;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LONG_LO,
    PH_LONG_HI,
    PH_ABS
  } phase_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [11:0] repeat_count;
    logic        last_of_run;
    logic        plane_end;
    logic        plane_full;
  } res_t;

  // Up to two results per decoded byte, vld[0] for res0, vld[1] for res1
  typedef struct packed {
    logic [1:0] vld;
    res_t       res1;
    res_t       res0;
  } push_t;

  typedef struct packed {
    logic                 room2;
    logic [RES_CNT_W-1:0] level;
  } fifo_stat_t;

endpackage

// ----- rtl/rle4_dec_core.sv -----
// Input register, parse state and plane limit logic of the decoder.
module rle4_dec_core
  import rle4_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic [BYTE_COUNT_WIDTH-1:0] plane_bytes,
  input  fifo_stat_t                  fstat,
  output push_t                       push
);

  // Input register
  logic       stg_vld_r;
  logic [7:0] stg_byte_r;
  logic       adv;

  // Parse state
  phase_t                      ph_r, ph_nxt;
  logic [3:0]                  held_r, held_nxt;
  logic                        odd_r, odd_nxt;
  logic [3:0]                  abs_r, abs_nxt;
  logic [7:0]                  cntlo_r, cntlo_nxt;
  logic [BYTE_COUNT_WIDTH-1:0] bw_r, bw_nxt;
  logic                        full_r, full_nxt;

  push_t dec;

  assign adv       = stg_vld_r && fstat.room2;
  assign in_tready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
    end
  end

  // Decode the staged byte
  always_comb begin
    logic [3:0]                  hi, lo, px;
    logic                        do_run, is_end;
    logic [11:0]                 run_len, len1;
    logic [1:0]                  rv;
    logic [7:0]                  rb [2];
    logic [11:0]                 rc [2];
    logic [1:0]                  ov;
    res_t                        ores [2];
    logic [BYTE_COUNT_WIDTH-1:0] room, cnt;
    logic                        full_v;
    logic [BYTE_COUNT_WIDTH-1:0] bw_v;

    hi = stg_byte_r[7:4];
    lo = stg_byte_r[3:0];
    px = lo;
    do_run = 1'b0;
    is_end = 1'b0;
    run_len = '0;
    len1 = '0;
    rv = '0;
    rb[0] = '0; rb[1] = '0;
    rc[0] = '0; rc[1] = '0;
    ov = '0;
    ores[0] = '0; ores[1] = '0;
    room = '0;
    cnt = '0;

    ph_nxt    = ph_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    abs_nxt   = abs_r;
    cntlo_nxt = cntlo_r;

    unique case (ph_r)
      PH_CODE: begin
        if (hi != 4'd0) begin
          do_run  = 1'b1;
          run_len = {8'd0, hi};
        end else if (lo == CODE_END) begin
          is_end = 1'b1;
        end else if (lo == CODE_LONG) begin
          ph_nxt = PH_LONG_LO;
        end else begin
          abs_nxt = lo;
          ph_nxt  = PH_ABS;
        end
      end
      PH_LONG_LO: begin
        cntlo_nxt = stg_byte_r;
        ph_nxt    = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        do_run  = 1'b1;
        run_len = {hi, cntlo_r};
        ph_nxt  = PH_CODE;
      end
      PH_ABS: begin
        // first nibble of the data byte
        if (odd_r) begin
          rv[0]   = 1'b1;
          rb[0]   = {held_r, hi};
          rc[0]   = 12'd1;
          odd_nxt = 1'b0;
        end else begin
          held_nxt = hi;
          odd_nxt  = 1'b1;
        end
        // second nibble only if the block still has two or more left
        if (abs_r >= 4'd2) begin
          if (odd_nxt) begin
            rv[0]   = 1'b1;
            rb[0]   = {held_nxt, lo};
            rc[0]   = 12'd1;
            odd_nxt = 1'b0;
          end else begin
            held_nxt = lo;
            odd_nxt  = 1'b1;
          end
          abs_nxt = abs_r - 4'd2;
        end else begin
          abs_nxt = 4'd0;
        end
        if (abs_nxt == 4'd0) begin
          ph_nxt = PH_CODE;
        end
      end
      default: ;
    endcase

    // Run: merge with a held pixel, then a doubled byte with a count
    if (do_run && run_len != 12'd0) begin
      len1 = run_len;
      if (odd_r) begin
        rv[0]   = 1'b1;
        rb[0]   = {held_r, px};
        rc[0]   = 12'd1;
        odd_nxt = 1'b0;
        len1    = run_len - 12'd1;
      end
      if (len1[11:1] != 11'd0) begin
        rv[1] = 1'b1;
        rb[1] = {px, px};
        rc[1] = {1'b0, len1[11:1]};
      end
      if (len1[0]) begin
        held_nxt = px;
        odd_nxt  = 1'b1;
      end
    end

    // Plane limit, applied to each write in order
    bw_v   = bw_r;
    full_v = full_r;
    for (int k = 0; k < 2; k++) begin
      if (rv[k] && !full_v) begin
        if (bw_v >= plane_bytes) begin
          full_v = 1'b1;
        end else begin
          room = plane_bytes - bw_v;
          cnt  = (BYTE_COUNT_WIDTH'(rc[k]) > room) ? room : BYTE_COUNT_WIDTH'(rc[k]);
          bw_v = bw_v + cnt;
          if (bw_v >= plane_bytes) begin
            full_v = 1'b1;
          end
          ov[k]                 = 1'b1;
          ores[k].out_byte      = rb[k];
          ores[k].repeat_count  = cnt[11:0];
          ores[k].plane_full    = full_v;
        end
      end
    end

    // Pack results in order and mark the final one
    dec = '0;
    if (is_end) begin
      dec.vld                = 2'b01;
      dec.res0.last_of_run   = 1'b1;
      dec.res0.plane_end     = 1'b1;
      dec.res0.plane_full    = full_r;
    end else if (ov == 2'b11) begin
      dec.vld              = 2'b11;
      dec.res0             = ores[0];
      dec.res1             = ores[1];
      dec.res1.last_of_run = 1'b1;
    end else if (ov != 2'b00) begin
      dec.vld              = 2'b01;
      dec.res0             = ov[0] ? ores[0] : ores[1];
      dec.res0.last_of_run = 1'b1;
    end

    bw_nxt   = bw_v;
    full_nxt = full_v;
    if (is_end) begin
      ph_nxt    = PH_CODE;
      held_nxt  = '0;
      odd_nxt   = 1'b0;
      abs_nxt   = '0;
      cntlo_nxt = '0;
      bw_nxt    = '0;
      full_nxt  = 1'b0;
    end
  end

  always_comb begin
    push     = dec;
    push.vld = adv ? dec.vld : 2'b00;
  end

  // State update on each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_CODE;
      held_r  <= '0;
      odd_r   <= 1'b0;
      abs_r   <= '0;
      cntlo_r <= '0;
      bw_r    <= '0;
      full_r  <= 1'b0;
    end else if (adv) begin
      ph_r    <= ph_nxt;
      held_r  <= held_nxt;
      odd_r   <= odd_nxt;
      abs_r   <= abs_nxt;
      cntlo_r <= cntlo_nxt;
      bw_r    <= bw_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

// ----- rtl/rle4_res_fifo.sv -----
// Result queue: takes up to two results a cycle, hands out one.
module rle4_res_fifo
  import rle4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output fifo_stat_t fstat,
  output logic       out_tvalid,
  input  logic       out_tready,
  output res_t       out_res
);

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, rd_r;
  logic [RES_CNT_W-1:0] level_r, level_nxt;
  logic                 pop;
  logic [RES_CNT_W-1:0] push_n;

  assign out_tvalid  = level_r != '0;
  assign out_res     = mem[rd_r];
  assign pop         = out_tvalid && out_tready;
  assign push_n      = RES_CNT_W'(push.vld[0]) + RES_CNT_W'(push.vld[1]);
  assign level_nxt   = level_r + push_n - RES_CNT_W'(pop);
  assign fstat.level = level_r;
  assign fstat.room2 = level_r <= RES_CNT_W'(RES_DEPTH - 2);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_r + RES_PTR_W'(push_n);
      rd_r    <= rd_r + RES_PTR_W'(pop);
      level_r <= level_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.vld[0]) begin
      mem[wr_r] <= push.res0;
    end
    if (push.vld[1]) begin
      mem[wr_r + RES_PTR_W'(1)] <= push.res1;
    end
  end

endmodule

// ----- rtl/rle4_nibble_run_decoder.sv -----
// Top level of the 4-bit run-length plane decoder.
//
// in_*  : one compressed byte per transaction (in_tdata).
// out_* : decoded results; out_tdata holds out_byte [7:0] and repeat_count
//         [19:8], out_tlast marks the last result of an input byte, out_tuser
//         holds plane_end [0] and plane_full [1].
// cfg_* : write of the plane size in bytes; it is always ready and must only
//         be written while the decoder is idle.
// A byte is held in the input register, then its results are written into a
// four-entry result queue, from which they are offered in order on out_*.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte that yields two results (merged byte
// plus doubled run byte) drains through the single output port of the queue.
// The input register advances only when the queue has room for two results,
// so a stalled receiver stops input after the queue fills, losing nothing.
// Reset clears the parse state, the byte counter and the queue, and loads
// the plane size of 307200 bytes.
module rle4_nibble_run_decoder
  import rle4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [19:8] repeat_count, [23:20] zero
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // [0] plane_end, [1] plane_full
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // [23:0] plane_bytes
);

  logic [BYTE_COUNT_WIDTH-1:0] plane_bytes_r;
  push_t                       push;
  fifo_stat_t                  fstat;
  res_t                        res;

  // Plane size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_bytes_r <= PLANE_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      plane_bytes_r <= cfg_data;
    end
  end

  rle4_dec_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .plane_bytes (plane_bytes_r),
    .fstat       (fstat),
    .push        (push)
  );

  rle4_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .fstat      (fstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'd0, res.repeat_count, res.out_byte};
  assign out_tlast = res.last_of_run;
  assign out_tuser = {res.plane_full, res.plane_end};

  // Results are packed in order: a second result never comes alone
  a_push_packed: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld[1] |-> push.vld[0])
    else $error("second result pushed without first");

  // Only the final result of a byte carries the last mark
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld[1] |-> (push.res1.last_of_run && !push.res0.last_of_run))
    else $error("last mark on wrong result");

  // The end code result is a lone zero-count result
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tdata[19:8] == 12'd0))
    else $error("end result malformed");

  // The queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

endmodule
